// File: sv/amx_pkg.sv
package amx_pkg;

  // Level and intermediate widths, sized to the worst case of each term
  localparam int LVL_W   = 4;
  localparam int P_W     = 5;   // pulse sum, up to 30
  localparam int PDEN_W  = 14;  // 8128 + 100*p, up to 11128
  localparam int N_W     = 19;  // 12241*tri + 8227*noise, up to 307020
  localparam int TDEN_W  = 27;  // 8227*12241 + 100*N, up to 131408707
  localparam int A_W     = 19;  // 9588*p
  localparam int B_W     = 33;  // 15979*N
  localparam int DENT_W  = 41;  // pden*tden
  localparam int NUM_W   = 48;  // full numerator and denominator
  localparam int SMP_W   = 16;  // output sample width
  localparam int CFG_W   = 4;

  // Mixer coefficients in exact integer form
  localparam logic [PDEN_W-1:0] PULSE_BIAS  = 14'd8128;
  localparam logic [6:0]        GROUP_SCALE = 7'd100;
  localparam logic [13:0]       PULSE_GAIN  = 14'd9588;
  localparam logic [13:0]       TND_GAIN    = 14'd15979;
  localparam logic [13:0]       TRI_DIV     = 14'd8227;
  localparam logic [13:0]       NOISE_DIV   = 14'd12241;
  localparam logic [TDEN_W-1:0] TND_BASE    = 27'd100706707;
  localparam logic [CFG_W-1:0]  ENABLE_ALL  = 4'hF;
  localparam logic [SMP_W-1:0]  SMP_MAX     = 16'hFFFF;

  // Channel enable bit positions
  localparam int EN_PULSE_ONE = 0;
  localparam int EN_PULSE_TWO = 1;
  localparam int EN_TRIANGLE  = 2;
  localparam int EN_NOISE     = 3;

endpackage

// File: sv/amx_ifs.sv
interface amx_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] pulse_one_level;
  logic [3:0] pulse_two_level;
  logic [3:0] triangle_level;
  logic [3:0] noise_level;

  modport source (output valid, pulse_one_level, pulse_two_level, triangle_level,
                  noise_level, input ready);
  modport sink (input valid, pulse_one_level, pulse_two_level, triangle_level,
                noise_level, output ready);
endinterface

interface amx_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mixed_sample;

  modport source (output valid, mixed_sample, input ready);
  modport sink (input valid, mixed_sample, output ready);
endinterface

interface amx_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] channel_enable;

  modport source (output valid, channel_enable, input ready);
  modport sink (input valid, channel_enable, output ready);
endinterface

// File: sv/apu_nonlinear_mixer.sv
// Nonlinear four-channel audio mixer. Each input word carries the 4-bit
// levels of two pulse channels, the triangle and the noise channel; each
// output word is the mixed sample as an unsigned fraction of full scale,
// truncated toward zero and clamped to 16 bits. A new word is accepted every
// cycle unless every stage is full behind a stalled result. Five stages
// build an exact integer numerator and denominator; then come one
// restoring-divider stage per result bit and the output register. The
// pipeline compacts bubbles, so input keeps flowing while a result waits
// until every stage is full. The channel enable register resets to all
// channels on and should be written only while the mixer is empty.
module apu_nonlinear_mixer
  import amx_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  amx_in_if.sink     in_word,
  amx_out_if.source  out_word,
  amx_cfg_if.sink    cfg_word
);

  localparam int QW  = OUT_FRAC_BITS;
  localparam int NST = OUT_FRAC_BITS + 6;
  localparam int DV0 = 5;  // first divider stage

  logic [CFG_W-1:0] enable_r;
  logic [NST-1:0]   vld_r;
  logic [NST-1:0]   adv;

  // Configuration register, always ready
  assign cfg_word.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= ENABLE_ALL;
    end else if (cfg_word.valid) begin
      enable_r <= cfg_word.channel_enable;
    end
  end

  // Advance chain: a stage loads when empty or when its successor loads
  always_comb begin
    adv[NST-1] = !vld_r[NST-1] || out_word.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_word.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_word.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Stage 0: mute disabled channels, sum the pulse pair
  logic [LVL_W-1:0] p1_in, p2_in, tri_in, noi_in;
  logic [P_W-1:0]   p0_r;
  logic [LVL_W-1:0] tri0_r, noi0_r;

  always_comb begin
    p1_in  = enable_r[EN_PULSE_ONE] ? in_word.pulse_one_level : '0;
    p2_in  = enable_r[EN_PULSE_TWO] ? in_word.pulse_two_level : '0;
    tri_in = enable_r[EN_TRIANGLE]  ? in_word.triangle_level  : '0;
    noi_in = enable_r[EN_NOISE]     ? in_word.noise_level     : '0;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p0_r   <= P_W'(p1_in) + P_W'(p2_in);
      tri0_r <= tri_in;
      noi0_r <= noi_in;
    end
  end

  // Stage 1: pulse denominator and weighted triangle/noise sum
  logic [P_W-1:0]    p1_r;
  logic [PDEN_W-1:0] pden1_r;
  logic [N_W-1:0]    n1_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p1_r    <= p0_r;
      pden1_r <= PULSE_BIAS + PDEN_W'(p0_r) * PDEN_W'(GROUP_SCALE);
      n1_r    <= N_W'(tri0_r) * N_W'(NOISE_DIV) + N_W'(noi0_r) * N_W'(TRI_DIV);
    end
  end

  // Stage 2: triangle/noise denominator and both group gains
  logic [TDEN_W-1:0] tden2_r;
  logic [PDEN_W-1:0] pden2_r;
  logic [A_W-1:0]    a2_r;
  logic [B_W-1:0]    b2_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      tden2_r <= TND_BASE + TDEN_W'(n1_r) * TDEN_W'(GROUP_SCALE);
      pden2_r <= pden1_r;
      a2_r    <= A_W'(p1_r) * A_W'(PULSE_GAIN);
      b2_r    <= B_W'(n1_r) * B_W'(TND_GAIN);
    end
  end

  // Stage 3: cross products
  logic [NUM_W-1:0]  numa3_r, numb3_r;
  logic [DENT_W-1:0] dent3_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      numa3_r <= NUM_W'(a2_r) * NUM_W'(tden2_r);
      numb3_r <= NUM_W'(b2_r) * NUM_W'(pden2_r);
      dent3_r <= DENT_W'(pden2_r) * DENT_W'(tden2_r);
    end
  end

  // Stage 4: final numerator and denominator (numerator always below)
  logic [NUM_W-1:0] num4_r, den4_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      num4_r <= numa3_r + numb3_r;
      den4_r <= NUM_W'(dent3_r) * NUM_W'(GROUP_SCALE);
    end
  end

  // Restoring divider, one quotient bit per stage
  logic [NUM_W-1:0] rem_r [QW];
  logic [NUM_W-1:0] dvd_r [QW];
  logic [QW-1:0]    q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NUM_W-1:0] rem_in, den_in;
    logic [QW-1:0]    q_in;
    logic [NUM_W:0]   rem_sh, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num4_r;
      assign den_in = den4_r;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = dvd_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign rem_sh = {rem_in, 1'b0};
    assign diff   = rem_sh - {1'b0, den_in};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (adv[DV0+k]) begin
        rem_r[k] <= ge ? diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
        dvd_r[k] <= den_in;
        q_r[k]   <= {q_in[QW-2:0], ge};
      end
    end
  end

  // Output stage: clamp to the sample width
  logic [SMP_W-1:0] sat_smp;
  logic [SMP_W-1:0] smp_r;

  if (QW > SMP_W) begin : g_clamp
    assign sat_smp = (|q_r[QW-1][QW-1:SMP_W]) ? SMP_MAX : q_r[QW-1][SMP_W-1:0];
  end else begin : g_pass
    assign sat_smp = SMP_W'(q_r[QW-1]);
  end

  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      smp_r <= sat_smp;
    end
  end

  assign out_word.valid        = vld_r[NST-1];
  assign out_word.mixed_sample = smp_r;

endmodule

// File: sv/amx_checker.sv
module amx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample
);

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("stalled result word changed");

  // Accept input whenever no result is pending
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Stall input only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind apu_nonlinear_mixer amx_checker u_amx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_word.ready),
  .out_valid  (out_word.valid),
  .out_ready  (out_word.ready),
  .out_sample (out_word.mixed_sample)
);

// File: tb/apu_nonlinear_mixer_test.sv
module apu_nonlinear_mixer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import amx_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int FRAC_BITS      = 16;
  localparam int MIX_LATENCY    = FRAC_BITS + 6;
  localparam int LONG_STALL     = 120;
  localparam int RANDOM_PER_SET = 85;
  localparam longint unsigned TIMEOUT_NS = 64'd300000 * CLK_PERIOD;

  // Mixer coefficients in integer form
  localparam longint unsigned K_PULSE_GAIN = 9588;
  localparam longint unsigned K_PULSE_BIAS = 8128;
  localparam longint unsigned K_SCALE      = 100;
  localparam longint unsigned K_TND_GAIN   = 15979;
  localparam longint unsigned K_TRI_DIV    = 8227;
  localparam longint unsigned K_NOISE_DIV  = 12241;

  typedef struct packed {
    logic [3:0] pulse_one;
    logic [3:0] pulse_two;
    logic [3:0] triangle;
    logic [3:0] noise;
  } levels_t;

  // Corner words: silence, full scale, each group alone, each channel alone
  localparam logic [15:0] CORNER_WORDS [19] = '{
    16'h0000, 16'hFFFF, 16'hFF00, 16'h00FF, 16'hF000, 16'h0F00, 16'h00F0,
    16'h000F, 16'h1000, 16'h0010, 16'h0001, 16'h1111, 16'h8888, 16'h7777,
    16'hA5A5, 16'h5A5A, 16'hE12D, 16'h0FF0, 16'hF00F
  };

  // Enable masks, six per idle phase, extremes and single channels included
  localparam logic [3:0] ENABLE_PLAN [18] = '{
    4'hF, 4'h0, 4'h1, 4'h2, 4'h4, 4'h8,
    4'h3, 4'hC, 4'hF, 4'h5, 4'hA, 4'h7,
    4'hB, 4'hD, 4'hE, 4'h6, 4'h9, 4'hF
  };
  localparam int SEND_IDLE [3] = '{9, 53, 0};
  localparam int RECV_IDLE [3] = '{53, 9, 0};

  logic clk;
  logic rst_n;

  amx_in_if  in_bus();
  amx_out_if out_bus();
  amx_cfg_if cfg_bus();

  apu_nonlinear_mixer #(
    .OUT_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_bus),
    .out_word (out_bus),
    .cfg_word (cfg_bus)
  );

  levels_t     pending_levels[$];
  logic [15:0] expected_samples[$];
  logic [3:0]  mix_enable = ENABLE_ALL;
  logic        in_taken = 1'b0;
  logic [15:0] want_sample;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        send_pause = 1'b0;
  int          stall_asks = 0;
  int          stalls_served = 0;
  int          stall_left = 0;
  int          miss_count = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Exact mix of the enabled levels, floored to the output fraction
  function automatic logic [15:0] mix_predict(logic [3:0] enable, levels_t lv);
    longint unsigned p1, p2, tri_lvl, noise_lvl;
    longint unsigned pulse_sum, tnd_sum, pulse_den, tnd_den, numer, denom;
    logic [127:0] scaled;
    p1        = enable[EN_PULSE_ONE] ? lv.pulse_one : 0;
    p2        = enable[EN_PULSE_TWO] ? lv.pulse_two : 0;
    tri_lvl   = enable[EN_TRIANGLE]  ? lv.triangle  : 0;
    noise_lvl = enable[EN_NOISE]     ? lv.noise     : 0;
    pulse_sum = p1 + p2;
    tnd_sum   = K_NOISE_DIV * tri_lvl + K_TRI_DIV * noise_lvl;
    pulse_den = K_PULSE_BIAS + K_SCALE * pulse_sum;
    tnd_den   = K_TRI_DIV * K_NOISE_DIV + K_SCALE * tnd_sum;
    numer     = K_PULSE_GAIN * pulse_sum * tnd_den + K_TND_GAIN * tnd_sum * pulse_den;
    denom     = K_SCALE * pulse_den * tnd_den;
    scaled    = (128'(numer) << FRAC_BITS) / denom;
    return (scaled > 128'hFFFF) ? 16'hFFFF : scaled[15:0];
  endfunction

  task automatic log_miss(string what, logic [15:0] want, logic [15:0] got);
    miss_count++;
    if (miss_count <= 10)
      $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Sample handshakes: track the enable, predict accepted words, check results
  always @(posedge clk) begin
    in_taken = rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready)
        mix_enable = cfg_bus.channel_enable;
      if (in_taken)
        expected_samples.push_back(mix_predict(mix_enable, '{in_bus.pulse_one_level,
            in_bus.pulse_two_level, in_bus.triangle_level, in_bus.noise_level}));
      if (out_bus.valid && out_bus.ready) begin
        if (expected_samples.size() == 0) begin
          log_miss("unexpected mixed_sample", 16'h0, out_bus.mixed_sample);
        end else begin
          want_sample = expected_samples.pop_front();
          if (out_bus.mixed_sample !== want_sample)
            log_miss("mixed_sample mismatch", want_sample, out_bus.mixed_sample);
        end
      end
    end
  end

  // Drive the next pending word once the current one is taken
  always @(negedge clk) begin
    levels_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (pending_levels.size() != 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_levels.pop_front();
        in_bus.pulse_one_level <= nxt.pulse_one;
        in_bus.pulse_two_level <= nxt.pulse_two;
        in_bus.triangle_level  <= nxt.triangle;
        in_bus.noise_level     <= nxt.noise;
        in_bus.valid           <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Accept results, with random gaps and an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_asks != stalls_served) begin
      out_bus.ready <= 1'b0;
      stall_left    <= LONG_STALL;
      stalls_served <= stall_asks;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_levels.size() != 0 || in_bus.valid || expected_samples.size() != 0);
  endtask

  task automatic write_enable(logic [3:0] mask);
    @(negedge clk);
    cfg_bus.channel_enable <= mask;
    cfg_bus.valid          <= 1'b1;
    do @(posedge clk);
    while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_random(int count);
    logic [15:0] word;
    repeat (count) begin
      word = $urandom();
      pending_levels.push_back(levels_t'(word));
    end
  endtask

  initial begin
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.pulse_one_level = '0;
    in_bus.pulse_two_level = '0;
    in_bus.triangle_level  = '0;
    in_bus.noise_level     = '0;
    out_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.channel_enable = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner words at the reset enable
    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];
    foreach (CORNER_WORDS[i])
      pending_levels.push_back(levels_t'(CORNER_WORDS[i]));

    // Random words over each idle pattern and a run of enable masks
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      recv_idle_pct = RECV_IDLE[ph];
      for (int s = 0; s < 6; s++) begin
        wait_drained();
        write_enable(ENABLE_PLAN[ph * 6 + s]);
        queue_random(RANDOM_PER_SET);
      end
    end
    wait_drained();

    // Hold off the receiver while words keep coming, so the input backs up
    stall_asks++;
    queue_random(80);
    wait_drained();

    // Pause the sender mid-stream until every result is back
    queue_random(60);
    do @(posedge clk);
    while (pending_levels.size() > 30);
    send_pause = 1'b1;
    do @(posedge clk);
    while (in_bus.valid || expected_samples.size() != 0);
    send_pause = 1'b0;
    wait_drained();

    // Let any stray result surface before the verdict
    repeat (MIX_LATENCY + 8) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $display("%0d results never arrived", expected_samples.size());
      miss_count += expected_samples.size();
    end
    if (miss_count == 0)
      $display("apu_nonlinear_mixer regression: pass");
    else
      $display("apu_nonlinear_mixer regression: fail");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout at %0t ns", $time);
    $display("apu_nonlinear_mixer regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
sv/amx_pkg.sv
sv/amx_ifs.sv
sv/apu_nonlinear_mixer.sv
sv/amx_checker.sv
tb/apu_nonlinear_mixer_test.sv
